/* design/mfs_pkg.sv */
// Shared types and constants for the scheduler arithmetic unit.
// No dependencies.
package mfs_pkg;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_RECENT = 2'd1,
      KIND_PRIO   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // aux carries the load-average numerator or the raw priority
   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] recent;
      logic signed [5:0]  nice;
      logic signed [35:0] aux;
   } side_type;

   localparam int AUX_W = 36;
   // floor(2^36 / 60): reciprocal for the divide by sixty
   localparam int RECIP_SHIFT = 36;
   localparam logic signed [31:0] RECIP_60 = 32'sd1145324612;
   localparam logic signed [63:0] SIXTY = 64'sd60;
   localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
   localparam logic [1:0] ADDR_PRI_MAX = 2'd0;
   localparam logic [5:0] PRI_MAX_RESET = 6'd63;

endpackage

/* design/mlfqs_fixed_point_scheduler_math.sv */
// Top level of the scheduler arithmetic unit: configuration register,
// front stage, divider chain and back end. Uses mfs_pkg, mfs_front, mfs_div_step and mfs_back.
//
//   channel   | ports                         | transfer when
//   ----------+-------------------------------+-------------------------------
//   request   | start, busy, req_*            | start high, busy low
//   response  | rsp_valid, rsp_value, rsp_sat.| rsp_valid high (one cycle)
//   config    | psel, penable, pwrite, paddr  | psel, penable, pwrite, pready
//
// The pipeline has one input stage, FRAC_BITS restoring
// division stages (one quotient bit each), then multiply, scale and
// saturate stages. One request enters every cycle; all kinds take the same
// path length so results leave in order. busy is high only during reset.
// The receiver cannot stall, so no result is ever held back.
module mlfqs_fixed_point_scheduler_math #(
   parameter int FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [21:0]        req_load_average,
   input  logic [7:0]         req_ready_count,
   input  logic signed [31:0] req_recent_usage,
   input  logic signed [5:0]  req_niceness,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_value,
   output logic               rsp_saturated,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   // remainder/divisor width: 2*load + 2^FRAC_BITS plus one guard bit
   localparam int DW = (FRAC_BITS + 2 > 24) ? FRAC_BITS + 2 : 24;

   logic [5:0] pri_max_ff;
   logic       accept;

   // divider chain taps
   logic                 dv_valid [0:FRAC_BITS];
   mfs_pkg::side_type    dv_side  [0:FRAC_BITS];
   logic [DW-1:0]        dv_rem   [0:FRAC_BITS];
   logic [DW-1:0]        dv_den   [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] dv_quo   [0:FRAC_BITS];

   assign busy   = reset;
   assign accept = start && !busy;
   assign pready = 1'b1;

   // Hold pri_max; write on the access phase of a write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         pri_max_ff <= mfs_pkg::PRI_MAX_RESET;
      end else if (psel && penable && pwrite && paddr == mfs_pkg::ADDR_PRI_MAX) begin
         pri_max_ff <= pwdata[5:0];
      end
   end

   assign prdata = (paddr == mfs_pkg::ADDR_PRI_MAX) ? {26'd0, pri_max_ff} : 32'd0;

   mfs_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .kind         (req_kind),
      .load_average (req_load_average),
      .ready_count  (req_ready_count),
      .recent_usage (req_recent_usage),
      .niceness     (req_niceness),
      .pri_max      (pri_max_ff),
      .out_valid    (dv_valid[0]),
      .out_side     (dv_side[0]),
      .out_rem      (dv_rem[0]),
      .out_den      (dv_den[0])
   );
   assign dv_quo[0] = '0;

   // Advance the coefficient division one quotient bit per stage
   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
      mfs_div_step #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[i]),
         .in_side   (dv_side[i]),
         .in_rem    (dv_rem[i]),
         .in_den    (dv_den[i]),
         .in_quo    (dv_quo[i]),
         .out_valid (dv_valid[i+1]),
         .out_side  (dv_side[i+1]),
         .out_rem   (dv_rem[i+1]),
         .out_den   (dv_den[i+1]),
         .out_quo   (dv_quo[i+1])
      );
   end

   mfs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (dv_valid[FRAC_BITS]),
      .in_side       (dv_side[FRAC_BITS]),
      .in_quo        (dv_quo[FRAC_BITS]),
      .out_valid     (rsp_valid),
      .out_value     (rsp_value),
      .out_saturated (rsp_saturated)
   );
endmodule

/* design/mfs_front.sv */
// Input stage: registers the request, forms the load-average numerator,
// the raw priority sum and the divider operands. Uses mfs_pkg.
module mfs_front #(
   parameter int FRAC_BITS = 14,
   parameter int DW = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [1:0]               kind,
   input  logic [21:0]              load_average,
   input  logic [7:0]               ready_count,
   input  logic signed [31:0]       recent_usage,
   input  logic signed [5:0]        niceness,
   input  logic [5:0]               pri_max,
   output logic                     out_valid,
   output mfs_pkg::side_type        out_side,
   output logic [DW-1:0]            out_rem,
   output logic [DW-1:0]            out_den
);
   localparam int AW = mfs_pkg::AUX_W;

   logic                   valid_ff;
   mfs_pkg::side_type      side_ff, side_in;
   logic [DW-1:0]          rem_ff, rem_in, den_ff, den_in;
   logic [AW-1:0]          num_u;
   logic signed [AW-1:0]   rec_w, rec_b, rec_q, pri_t, nice_t;

   always_comb begin
      num_u  = (AW'(load_average) * AW'(59)) + (AW'(ready_count) << FRAC_BITS);
      rec_w  = AW'(recent_usage);
      // truncate toward zero: bias negatives before the shift
      rec_b  = rec_w + (rec_w[AW-1] ? AW'(3) : AW'(0));
      rec_q  = rec_b >>> 2;
      pri_t  = $signed(AW'(pri_max) << FRAC_BITS);
      nice_t = AW'(niceness) <<< (FRAC_BITS + 1);
      side_in.kind   = mfs_pkg::kind_type'(kind);
      side_in.recent = recent_usage;
      side_in.nice   = niceness;
      if (kind == mfs_pkg::KIND_LOAD) begin
         side_in.aux = $signed(num_u);
      end else begin
         side_in.aux = pri_t - rec_q - nice_t;
      end
      rem_in = DW'({load_average, 1'b0});
      den_in = DW'({load_average, 1'b0}) + (DW'(1) << FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= side_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
endmodule

/* design/mfs_div_step.sv */
// One restoring-division stage: produces one quotient bit per cycle.
// Uses mfs_pkg for the sideband type.
module mfs_div_step #(
   parameter int FRAC_BITS = 14,
   parameter int DW = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  mfs_pkg::side_type    in_side,
   input  logic [DW-1:0]        in_rem,
   input  logic [DW-1:0]        in_den,
   input  logic [FRAC_BITS-1:0] in_quo,
   output logic                 out_valid,
   output mfs_pkg::side_type    out_side,
   output logic [DW-1:0]        out_rem,
   output logic [DW-1:0]        out_den,
   output logic [FRAC_BITS-1:0] out_quo
);
   logic                 valid_ff;
   mfs_pkg::side_type    side_ff;
   logic [DW-1:0]        rem_ff, rem_in, den_ff;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [DW:0]          trial;

   always_comb begin
      trial = {in_rem, 1'b0};
      if (trial >= {1'b0, in_den}) begin
         rem_in = DW'(trial - {1'b0, in_den});
         quo_in = {in_quo[FRAC_BITS-2:0], 1'b1};
      end else begin
         rem_in = DW'(trial);
         quo_in = {in_quo[FRAC_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= in_side;
      rem_ff  <= rem_in;
      den_ff  <= in_den;
      quo_ff  <= quo_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
endmodule

/* design/mfs_back.sv */
// Back end: shared multiplier, scaling and rounding, then correction and
// saturation into the result register. Uses mfs_pkg.
module mfs_back #(
   parameter int FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  mfs_pkg::side_type    in_side,
   input  logic [FRAC_BITS-1:0] in_quo,
   output logic                 out_valid,
   output logic signed [31:0]   out_value,
   output logic                 out_saturated
);
   localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   // multiply stage
   logic               mul_valid_ff;
   mfs_pkg::side_type  mul_side_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic [30:0]        op_a;
   logic signed [31:0] op_b;

   // scale stage
   logic               scl_valid_ff;
   mfs_pkg::kind_type  scl_kind_ff;
   logic signed [63:0] scl_val_ff, scl_val_in;
   logic               scl_inc_ff, scl_inc_in;
   logic signed [63:0] q0, resid, trunc_v, aux_w, rnd;

   // result stage
   logic               res_valid_ff;
   logic signed [31:0] res_value_ff, res_value_in;
   logic               res_sat_ff, res_sat_in;
   logic signed [63:0] fin;

   always_comb begin
      if (in_side.kind == mfs_pkg::KIND_LOAD) begin
         op_a = 31'(in_side.aux);
         op_b = mfs_pkg::RECIP_60;
      end else begin
         op_a = 31'(in_quo);
         op_b = in_side.recent;
      end
      prod_in = $signed({1'b0, op_a}) * op_b;
   end

   always_comb begin
      aux_w   = 64'(mul_side_ff.aux);
      q0      = prod_ff >>> mfs_pkg::RECIP_SHIFT;
      resid   = aux_w - q0 * mfs_pkg::SIXTY;
      trunc_v = (prod_ff + (prod_ff[63] ? ONE - 64'sd1 : 64'sd0)) >>> FRAC_BITS;
      rnd     = aux_w[63] ? ((aux_w - HALF + ONE - 64'sd1) >>> FRAC_BITS)
                          : ((aux_w + HALF) >>> FRAC_BITS);
      scl_inc_in = 1'b0;
      case (mul_side_ff.kind)
         mfs_pkg::KIND_LOAD: begin
            scl_val_in = q0;
            scl_inc_in = (resid >= mfs_pkg::SIXTY);
         end
         mfs_pkg::KIND_RECENT: begin
            scl_val_in = trunc_v + (64'(mul_side_ff.nice) <<< FRAC_BITS);
         end
         mfs_pkg::KIND_PRIO: begin
            scl_val_in = rnd;
         end
         default: begin
            scl_val_in = 64'sd0;
         end
      endcase
   end

   always_comb begin
      fin = scl_val_ff + (scl_inc_ff ? 64'sd1 : 64'sd0);
      res_sat_in = 1'b0;
      if (scl_kind_ff == mfs_pkg::KIND_NONE) begin
         res_value_in = 32'sd0;
      end else if (fin > mfs_pkg::I32_MAX) begin
         res_value_in = 32'(mfs_pkg::I32_MAX);
         res_sat_in   = 1'b1;
      end else if (fin < mfs_pkg::I32_MIN) begin
         res_value_in = 32'(mfs_pkg::I32_MIN);
         res_sat_in   = 1'b1;
      end else begin
         res_value_in = 32'(fin);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         scl_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         scl_valid_ff <= mul_valid_ff;
         res_valid_ff <= scl_valid_ff;
      end
      mul_side_ff  <= in_side;
      prod_ff      <= prod_in;
      scl_kind_ff  <= mul_side_ff.kind;
      scl_val_ff   <= scl_val_in;
      scl_inc_ff   <= scl_inc_in;
      res_value_ff <= res_value_in;
      res_sat_ff   <= res_sat_in;
   end

   assign out_valid     = res_valid_ff;
   assign out_value     = res_value_ff;
   assign out_saturated = res_sat_ff;
endmodule

/* design/mfs_checker.sv */
// Port-level checks for the scheduler arithmetic unit, bound to the top.
// Depends on mfs_pkg and mlfqs_fixed_point_scheduler_math.
module mfs_checker #(
   parameter int FRAC_BITS = 14
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_kind,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_value,
   input logic               rsp_saturated
);
   localparam int LAT = FRAC_BITS + 4;

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("transfer without a response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response without a transfer");

   a_unused_kind: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == mfs_pkg::KIND_NONE) |->
         ##LAT (rsp_value == 32'sd0 && !rsp_saturated))
      else $error("unused kind gave a non-zero result");

   a_load_no_sat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == mfs_pkg::KIND_LOAD) |-> ##LAT !rsp_saturated)
      else $error("load average saturated");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_value == 32'sh7fffffff || rsp_value == 32'sh80000000))
      else $error("saturated result not at a bound");
endmodule

bind mlfqs_fixed_point_scheduler_math mfs_checker #(.FRAC_BITS(FRAC_BITS)) u_mfs_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_kind      (req_kind),
   .rsp_valid     (rsp_valid),
   .rsp_value     (rsp_value),
   .rsp_saturated (rsp_saturated)
);
